>>> sv/dense_cholesky_solver_assert.svh
// Assertion macros for the dense Cholesky solver.
`ifndef DENSE_CHOLESKY_SOLVER_ASSERT_SVH
`define DENSE_CHOLESKY_SOLVER_ASSERT_SVH
`ifndef SYNTHESIS
// prop must hold at every rising clock edge outside reset
`define DCS_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dcs assertion failed");
// cond must never be true outside reset
`define DCS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("dcs forbidden condition");
`else
`define DCS_ASSERT_CLK(lbl, clk, rst_n, prop)
`define DCS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> sv/dcs_pkg.sv
// Shared types and constants of the dense Cholesky solver.
package dcs_pkg;

    localparam int MAX_ORDER_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [4:0]  MATRIX_SIZE_RESET = 5'd16;
    localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;
    localparam int          SQRT_STEPS = 32;

    typedef enum logic [1:0] {
        OP_WR_MAT = 2'd0,
        OP_WR_RHS = 2'd1,
        OP_FACTOR = 2'd2,
        OP_SOLVE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_PIVOT = 2'd1,
        STAT_SAT   = 2'd2
    } status_t;

    localparam logic KIND_STATUS   = 1'b0;
    localparam logic KIND_SOLUTION = 1'b1;

    // which reduction the sequencer is running
    typedef enum logic [1:0] {
        PH_DIAG,
        PH_OFF,
        PH_FWD,
        PH_BWD
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BASE_RD,
        ST_BASE_LD,
        ST_PROD_RD,
        ST_PROD_MUL,
        ST_PROD_ACC,
        ST_POST,
        ST_SQRT_WAIT,
        ST_DIV_WAIT,
        ST_WRITE,
        ST_FIN,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    typedef struct packed {
        logic        done;
        logic        sat;
        logic [31:0] quot;
    } div_res_t;

endpackage

>>> sv/dense_cholesky_solver.sv
// Dense Cholesky factor and solve engine, signed fixed point, top level.
//
// Requests enter on s_tvalid/s_tready: s_tuser holds the opcode, s_tdata holds
// row, col and value. Matrix and rhs writes are taken while idle and give no
// result. A factor request replaces the lower triangle with L and returns one
// status result; a solve request returns n solution elements, index 0 first,
// with m_tlast on the final one. cfg_wr_en/cfg_wr_data set the order n and
// may only be written while the block is idle.
// Each multiply-accumulate runs as read, multiply and accumulate steps on
// the shared matrix memory read ports; each reduction adds the base read,
// base load, post and write steps. Divisions run in the bit-serial divider
// and square roots in the digit-by-digit root unit.
// Reset clears the sequencer, the output valid flag and sets n to 16; the
// stores themselves are not cleared and must be written before use.
// A new request is taken whenever the sequencer is idle, even while the last
// result still sits in the output register; if m_tready stays low the
// sequencer holds before writing the next result into that register.
`include "dense_cholesky_solver_assert.svh"

module dense_cholesky_solver #(
    parameter int MAX_ORDER = dcs_pkg::MAX_ORDER_DEF,
    parameter int FRAC_BITS = dcs_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,   // matrix_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // row[3:0], col[7:4], value[39:8]
    input  logic [1:0]  s_tuser,       // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,       // index[3:0], result_value[35:4],
                                       // status[37:36], zero[39:38]
    output logic [0:0]  m_tuser,       // kind
    output logic        m_tlast
);

    localparam int IW  = $clog2(MAX_ORDER);
    localparam int NW  = $clog2(MAX_ORDER + 1);
    localparam int MAW = 2 * IW;

    dcs_pkg::state_t state_reg, state_next;
    dcs_pkg::phase_t phase_reg;

    logic [4:0]         size_reg;
    logic [NW-1:0]      n_eff;
    logic [NW-1:0]      row_reg;
    logic [NW-1:0]      sub_reg;
    logic [NW-1:0]      k_reg;
    logic [NW-1:0]      k_start;
    logic [NW-1:0]      k_end;
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic [31:0]        diag_reg;
    logic [31:0]        res_reg;
    logic               bad_reg;
    logic               sat_reg;

    logic               out_valid_reg;
    logic [3:0]         out_index_reg;
    logic [31:0]        out_value_reg;
    logic [1:0]         out_status_reg;
    logic               out_kind_reg;
    logic               out_last_reg;

    // input unpacking
    logic               accept;
    dcs_pkg::opcode_t   in_op;
    logic [3:0]         in_row;
    logic [3:0]         in_col;
    logic [31:0]        in_value;
    logic               row_ok;
    logic               col_ok;

    // memory ports
    logic               mat_we;
    logic [MAW-1:0]     mat_waddr;
    logic [31:0]        mat_wdata;
    logic [MAW-1:0]     mat_raddr_a;
    logic [MAW-1:0]     mat_raddr_b;
    logic [31:0]        mat_rdata_a;
    logic [31:0]        mat_rdata_b;
    logic               rhs_we;
    logic [IW-1:0]      rhs_raddr;
    logic [31:0]        rhs_rdata;
    logic               work_we;
    logic [IW-1:0]      work_raddr;
    logic [31:0]        work_rdata;

    logic               sqrt_start;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;
    logic               div_start;
    dcs_pkg::div_res_t  div_res;

    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      s_idx;
    logic [IW-1:0]      k_idx;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic [31:0]        base_val;
    logic [31:0]        post_val;
    logic               post_ovf;
    logic               post_pos;
    logic               slot_free;
    logic               load_fin;
    logic               load_emit;
    dcs_pkg::status_t   cmd_status;

    assign accept   = s_tvalid && s_tready;
    assign in_op    = dcs_pkg::opcode_t'(s_tuser);
    assign in_row   = s_tdata[3:0];
    assign in_col   = s_tdata[7:4];
    assign in_value = s_tdata[39:8];
    assign row_ok   = {28'd0, in_row} < 32'(MAX_ORDER);
    assign col_ok   = {28'd0, in_col} < 32'(MAX_ORDER);

    // order in use: zero counts as one, clamp to the built size
    assign n_eff = (size_reg == '0) ? NW'(1) :
                   ({27'd0, size_reg} > 32'(MAX_ORDER)) ? NW'(MAX_ORDER) :
                   NW'(size_reg);

    assign r_idx = row_reg[IW-1:0];
    assign s_idx = sub_reg[IW-1:0];
    assign k_idx = k_reg[IW-1:0];

    // backward pass sums over later rows, all others over earlier columns
    assign k_start = (phase_reg == dcs_pkg::PH_BWD) ? NW'(row_reg + NW'(1)) : '0;
    assign k_end   = (phase_reg == dcs_pkg::PH_BWD) ? n_eff : row_reg;

    // saturate the accumulated sum to 32 bits
    assign post_ovf = acc_reg != {{32{acc_reg[31]}}, acc_reg[31:0]};
    assign post_val = !post_ovf ? acc_reg[31:0] :
                      (acc_reg[63] ? dcs_pkg::SAT_NEG : dcs_pkg::SAT_POS);
    assign post_pos = !post_val[31] && (post_val != '0);

    assign mul_a = mat_rdata_a;
    always_comb begin
        unique case (phase_reg)
            dcs_pkg::PH_DIAG: mul_b = mat_rdata_a;
            dcs_pkg::PH_OFF:  mul_b = mat_rdata_b;
            default:          mul_b = work_rdata;
        endcase
    end

    always_comb begin
        unique case (phase_reg)
            dcs_pkg::PH_FWD: base_val = rhs_rdata;
            dcs_pkg::PH_BWD: base_val = work_rdata;
            default:         base_val = mat_rdata_a;
        endcase
    end

    assign slot_free  = !out_valid_reg || m_tready;
    assign load_fin   = (state_reg == dcs_pkg::ST_FIN) && slot_free;
    assign load_emit  = (state_reg == dcs_pkg::ST_EMIT_OUT) && slot_free;
    assign cmd_status = bad_reg ? dcs_pkg::STAT_PIVOT :
                        (sat_reg ? dcs_pkg::STAT_SAT : dcs_pkg::STAT_OK);
    // no request is taken while reset is held
    assign s_tready   = aresetn && (state_reg == dcs_pkg::ST_IDLE);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dcs_pkg::ST_IDLE: begin
                if (accept && (in_op == dcs_pkg::OP_FACTOR || in_op == dcs_pkg::OP_SOLVE)) begin
                    state_next = dcs_pkg::ST_BASE_RD;
                end
            end
            dcs_pkg::ST_BASE_RD:  state_next = dcs_pkg::ST_BASE_LD;
            dcs_pkg::ST_BASE_LD: begin
                state_next = (k_start == k_end) ? dcs_pkg::ST_POST : dcs_pkg::ST_PROD_RD;
            end
            dcs_pkg::ST_PROD_RD:  state_next = dcs_pkg::ST_PROD_MUL;
            dcs_pkg::ST_PROD_MUL: state_next = dcs_pkg::ST_PROD_ACC;
            dcs_pkg::ST_PROD_ACC: begin
                state_next = (NW'(k_reg + NW'(1)) == k_end) ? dcs_pkg::ST_POST
                                                            : dcs_pkg::ST_PROD_RD;
            end
            dcs_pkg::ST_POST: begin
                if (phase_reg == dcs_pkg::PH_DIAG) begin
                    state_next = post_pos ? dcs_pkg::ST_SQRT_WAIT : dcs_pkg::ST_FIN;
                end else begin
                    state_next = dcs_pkg::ST_DIV_WAIT;
                end
            end
            dcs_pkg::ST_SQRT_WAIT: begin
                if (sqrt_done) state_next = dcs_pkg::ST_WRITE;
            end
            dcs_pkg::ST_DIV_WAIT: begin
                if (div_res.done) state_next = dcs_pkg::ST_WRITE;
            end
            dcs_pkg::ST_WRITE: begin
                unique case (phase_reg)
                    dcs_pkg::PH_DIAG: begin
                        state_next = (NW'(row_reg + NW'(1)) < n_eff) ? dcs_pkg::ST_BASE_RD
                                                                     : dcs_pkg::ST_FIN;
                    end
                    dcs_pkg::PH_BWD: begin
                        state_next = (row_reg == '0) ? dcs_pkg::ST_EMIT_RD
                                                     : dcs_pkg::ST_BASE_RD;
                    end
                    default: state_next = dcs_pkg::ST_BASE_RD;
                endcase
            end
            dcs_pkg::ST_FIN: begin
                if (slot_free) state_next = dcs_pkg::ST_IDLE;
            end
            dcs_pkg::ST_EMIT_RD: state_next = dcs_pkg::ST_EMIT_OUT;
            dcs_pkg::ST_EMIT_OUT: begin
                if (slot_free) begin
                    state_next = (NW'(row_reg + NW'(1)) == n_eff) ? dcs_pkg::ST_IDLE
                                                                  : dcs_pkg::ST_EMIT_RD;
                end
            end
            default: state_next = dcs_pkg::ST_IDLE;
        endcase
    end

    // memory addressing, write strobes and unit starts
    always_comb begin
        mat_we      = 1'b0;
        mat_waddr   = {r_idx, r_idx};
        mat_wdata   = res_reg;
        mat_raddr_a = {r_idx, k_idx};
        mat_raddr_b = {r_idx, k_idx};
        rhs_we      = 1'b0;
        rhs_raddr   = r_idx;
        work_we     = 1'b0;
        work_raddr  = k_idx;
        sqrt_start  = 1'b0;
        div_start   = 1'b0;
        unique case (state_reg)
            dcs_pkg::ST_IDLE: begin
                mat_waddr = {IW'(in_row), IW'(in_col)};
                mat_wdata = in_value;
                mat_we    = accept && in_op == dcs_pkg::OP_WR_MAT && row_ok && col_ok;
                rhs_we    = accept && in_op == dcs_pkg::OP_WR_RHS && row_ok;
            end
            dcs_pkg::ST_BASE_RD: begin
                // port b fetches the diagonal the solve divides by
                mat_raddr_b = {r_idx, r_idx};
                mat_raddr_a = (phase_reg == dcs_pkg::PH_OFF) ? {s_idx, r_idx}
                                                             : {r_idx, r_idx};
                work_raddr  = r_idx;
            end
            dcs_pkg::ST_PROD_RD: begin
                unique case (phase_reg)
                    dcs_pkg::PH_OFF: mat_raddr_a = {s_idx, k_idx};
                    dcs_pkg::PH_BWD: mat_raddr_a = {k_idx, r_idx};
                    default:         mat_raddr_a = {r_idx, k_idx};
                endcase
            end
            dcs_pkg::ST_POST: begin
                sqrt_start = (phase_reg == dcs_pkg::PH_DIAG) && post_pos;
                div_start  = (phase_reg != dcs_pkg::PH_DIAG);
            end
            dcs_pkg::ST_WRITE: begin
                unique case (phase_reg)
                    dcs_pkg::PH_DIAG: mat_we = 1'b1;
                    dcs_pkg::PH_OFF: begin
                        mat_we    = 1'b1;
                        mat_waddr = {s_idx, r_idx};
                    end
                    default: work_we = 1'b1;
                endcase
            end
            dcs_pkg::ST_EMIT_RD, dcs_pkg::ST_EMIT_OUT: work_raddr = r_idx;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dcs_pkg::ST_IDLE;
            size_reg  <= dcs_pkg::MATRIX_SIZE_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) size_reg <= cfg_wr_data;
        end
    end

    // sequencer counters and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= dcs_pkg::PH_DIAG;
            row_reg   <= '0;
            sub_reg   <= '0;
            k_reg     <= '0;
            bad_reg   <= 1'b0;
            sat_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                dcs_pkg::ST_IDLE: begin
                    if (accept && in_op == dcs_pkg::OP_FACTOR) begin
                        phase_reg <= dcs_pkg::PH_DIAG;
                        row_reg   <= '0;
                        bad_reg   <= 1'b0;
                        sat_reg   <= 1'b0;
                    end else if (accept && in_op == dcs_pkg::OP_SOLVE) begin
                        phase_reg <= dcs_pkg::PH_FWD;
                        row_reg   <= '0;
                        bad_reg   <= 1'b0;
                        sat_reg   <= 1'b0;
                    end
                end
                dcs_pkg::ST_BASE_LD:  k_reg <= k_start;
                dcs_pkg::ST_PROD_ACC: k_reg <= NW'(k_reg + NW'(1));
                dcs_pkg::ST_POST: begin
                    if (post_ovf) sat_reg <= 1'b1;
                    if (phase_reg == dcs_pkg::PH_DIAG && !post_pos) bad_reg <= 1'b1;
                    if (phase_reg == dcs_pkg::PH_FWD &&
                        (diag_reg[31] || diag_reg == '0)) bad_reg <= 1'b1;
                end
                dcs_pkg::ST_DIV_WAIT: begin
                    if (div_res.done && div_res.sat) sat_reg <= 1'b1;
                end
                dcs_pkg::ST_WRITE: begin
                    unique case (phase_reg)
                        dcs_pkg::PH_DIAG: begin
                            if (NW'(row_reg + NW'(1)) < n_eff) begin
                                phase_reg <= dcs_pkg::PH_OFF;
                                sub_reg   <= NW'(row_reg + NW'(1));
                            end
                        end
                        dcs_pkg::PH_OFF: begin
                            if (NW'(sub_reg + NW'(1)) < n_eff) begin
                                sub_reg <= NW'(sub_reg + NW'(1));
                            end else begin
                                phase_reg <= dcs_pkg::PH_DIAG;
                                row_reg   <= NW'(row_reg + NW'(1));
                            end
                        end
                        dcs_pkg::PH_FWD: begin
                            if (NW'(row_reg + NW'(1)) < n_eff) begin
                                row_reg <= NW'(row_reg + NW'(1));
                            end else begin
                                phase_reg <= dcs_pkg::PH_BWD;
                                row_reg   <= NW'(n_eff - NW'(1));
                            end
                        end
                        default: begin
                            if (row_reg != '0) row_reg <= NW'(row_reg - NW'(1));
                        end
                    endcase
                end
                dcs_pkg::ST_EMIT_OUT: begin
                    if (slot_free) row_reg <= NW'(row_reg + NW'(1));
                end
                default: ;
            endcase
        end
    end

    // arithmetic datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            dcs_pkg::ST_BASE_LD: begin
                acc_reg <= {{32{base_val[31]}}, base_val};
                if (phase_reg == dcs_pkg::PH_FWD || phase_reg == dcs_pkg::PH_BWD) begin
                    diag_reg <= mat_rdata_b;
                end
            end
            dcs_pkg::ST_PROD_MUL: prod_reg <= mul_a * mul_b;
            dcs_pkg::ST_PROD_ACC: acc_reg <= acc_reg - (prod_reg >>> FRAC_BITS);
            dcs_pkg::ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    res_reg  <= sqrt_root;
                    diag_reg <= sqrt_root;
                end
            end
            dcs_pkg::ST_DIV_WAIT: begin
                if (div_res.done) res_reg <= div_res.quot;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_fin || load_emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_fin) begin
            out_kind_reg   <= dcs_pkg::KIND_STATUS;
            out_index_reg  <= '0;
            out_value_reg  <= '0;
            out_status_reg <= cmd_status;
            out_last_reg   <= 1'b1;
        end else if (load_emit) begin
            out_kind_reg   <= dcs_pkg::KIND_SOLUTION;
            out_index_reg  <= 4'(row_reg);
            out_value_reg  <= work_rdata;
            out_status_reg <= cmd_status;
            out_last_reg   <= (NW'(row_reg + NW'(1)) == n_eff);
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {2'b00, out_status_reg, out_value_reg, out_index_reg};
    assign m_tuser[0] = out_kind_reg;
    assign m_tlast    = out_last_reg;

    dcs_mat_ram #(
        .AW (MAW)
    ) u_mat (
        .aclk    (aclk),
        .we      (mat_we),
        .waddr   (mat_waddr),
        .wdata   (mat_wdata),
        .raddr_a (mat_raddr_a),
        .raddr_b (mat_raddr_b),
        .rdata_a (mat_rdata_a),
        .rdata_b (mat_rdata_b)
    );

    dcs_vec_ram #(
        .AW (IW)
    ) u_rhs (
        .aclk  (aclk),
        .we    (rhs_we),
        .waddr (IW'(in_row)),
        .wdata (in_value),
        .raddr (rhs_raddr),
        .rdata (rhs_rdata)
    );

    dcs_vec_ram #(
        .AW (IW)
    ) u_work (
        .aclk  (aclk),
        .we    (work_we),
        .waddr (r_idx),
        .wdata (res_reg),
        .raddr (work_raddr),
        .rdata (work_rdata)
    );

    dcs_sqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .s       (post_val),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    dcs_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (post_val),
        .den     (diag_reg),
        .res     (div_res)
    );

    // unit completions only arrive while the sequencer waits for them
    `DCS_ASSERT_NEVER(a_div_done_wait, aclk, aresetn, div_res.done && state_reg != dcs_pkg::ST_DIV_WAIT)
    `DCS_ASSERT_NEVER(a_sqrt_done_wait, aclk, aresetn, sqrt_done && state_reg != dcs_pkg::ST_SQRT_WAIT)
    // the last solution element carries index n-1
    `DCS_ASSERT_CLK(a_last_index, aclk, aresetn, (m_tvalid && m_tuser[0] && m_tlast) |-> (m_tdata[3:0] == 4'(n_eff - NW'(1))))

endmodule

>>> sv/dcs_mat_ram.sv
// Matrix store: one write port, two registered read ports.
module dcs_mat_ram #(
    parameter int AW = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [31:0]   rdata_a,
    output logic [31:0]   rdata_b
);

    logic [31:0] mem [1<<AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> sv/dcs_vec_ram.sv
// Vector store: one write port, one registered read port.
module dcs_vec_ram #(
    parameter int AW = 4
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [1<<AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/dcs_sqrt.sv
// Digit-by-digit square root of s * 2^FRAC_BITS, two radicand bits per cycle.
module dcs_sqrt #(
    parameter int FRAC_BITS = dcs_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] s,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] x_reg;
    logic [34:0] rem_reg;
    logic [31:0] root_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;

    assign rem_sh = {rem_reg[32:0], x_reg[63:62]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= 6'(dcs_pkg::SQRT_STEPS);
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_reg - 6'd1;
                done_reg <= (cnt_reg == 6'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= {32'd0, s} << FRAC_BITS;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cnt_reg != '0) begin
            x_reg    <= {x_reg[61:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> sv/dcs_div.sv
// Restoring divider: (num * 2^FRAC_BITS) / den, truncated, saturated to 32 bits.
module dcs_div #(
    parameter int FRAC_BITS = dcs_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [31:0]       num,
    input  logic [31:0]       den,
    output dcs_pkg::div_res_t res
);

    localparam int DW = 32 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] dvd_reg;
    logic [DW-1:0] quo_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          neg_reg;
    logic          done_reg;
    logic          sat_reg;
    logic [31:0]   q_reg;

    logic [31:0]   abs_num;
    logic [31:0]   abs_den;
    logic [32:0]   rem_sh;
    logic          ge;
    logic          hi;
    logic          ovf;

    assign abs_num = num[31] ? (32'd0 - num) : num;
    assign abs_den = den[31] ? (32'd0 - den) : den;
    assign rem_sh  = {rem_reg, dvd_reg[DW-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign hi      = |quo_reg[DW-1:32];
    assign ovf     = neg_reg ? (hi || (quo_reg[31] && (|quo_reg[30:0])))
                             : (hi || quo_reg[31]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= (den != '0);
                done_reg <= (den == '0);
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {abs_num, {FRAC_BITS{1'b0}}};
            dvs_reg <= abs_den;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= CW'(DW);
            neg_reg <= num[31] ^ den[31];
            // zero divisor: answer at once with the numerator's sign
            sat_reg <= (num != '0);
            q_reg   <= (num == '0) ? '0 : (num[31] ? dcs_pkg::SAT_NEG : dcs_pkg::SAT_POS);
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                rem_reg <= ge ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
                quo_reg <= {quo_reg[DW-2:0], ge};
                dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
                cnt_reg <= cnt_reg - CW'(1);
            end else begin
                sat_reg <= ovf;
                if (ovf) begin
                    q_reg <= neg_reg ? dcs_pkg::SAT_NEG : dcs_pkg::SAT_POS;
                end else begin
                    q_reg <= neg_reg ? (32'd0 - quo_reg[31:0]) : quo_reg[31:0];
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.sat  = sat_reg;
    assign res.quot = q_reg;

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the dense Cholesky factor and solve engine.
`timescale 1ns / 100ps

module testbench;
    import dcs_pkg::*;

    localparam int ORDER_MAX  = MAX_ORDER_DEF;
    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int STALL_LIMIT = 60000;
    localparam int RANDOM_ITEMS = 100;

    typedef struct {
        logic        kind;
        logic [3:0]  index;
        logic [31:0] value;
        status_t     status;
        logic        last;
    } solver_result_t;

    // Tracks the block's stores and predicts the results of each request.
    class cholesky_tracker;
        int             mat [ORDER_MAX*ORDER_MAX];
        int             rhs [ORDER_MAX];
        int             work [ORDER_MAX];
        logic [4:0]     size_reg;
        bit             sat_seen;
        solver_result_t pending_results[$];
        int             mismatches;
        int             checked;

        function new();
            size_reg = MATRIX_SIZE_RESET;
        endfunction

        function int order();
            if (size_reg == 0) return 1;
            if (size_reg > ORDER_MAX) return ORDER_MAX;
            return size_reg;
        endfunction

        function int clamp32(longint x);
            if (x > longint'(32'sh7fffffff)) begin
                sat_seen = 1;
                return 32'sh7fffffff;
            end
            if (x < -longint'(64'sh80000000)) begin
                sat_seen = 1;
                return 32'sh80000000;
            end
            return int'(x);
        endfunction

        function longint fx_mul(int a, int b);
            longint p;
            p = longint'(a) * longint'(b);
            return p >>> FRAC;
        endfunction

        function int fx_div(int num, int den);
            if (den == 0) begin
                if (num == 0) return 0;
                sat_seen = 1;
                return (num > 0) ? 32'sh7fffffff : 32'sh80000000;
            end
            return clamp32((longint'(num) <<< FRAC) / longint'(den));
        endfunction

        // bit-by-bit integer root of s scaled by the fraction
        function int fx_root(int s);
            bit [63:0] v;
            bit [63:0] r;
            bit [63:0] t;
            v = {32'b0, s} << FRAC;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) r = t;
            end
            return clamp32(longint'(r));
        endfunction

        function void note_config(logic [4:0] val);
            size_reg = val;
        endfunction

        function void note_request(opcode_t op, logic [3:0] row, logic [3:0] col,
                                   logic [31:0] val);
            int n;
            bit bad;
            longint acc;
            int s;
            int d;
            status_t st;
            solver_result_t res;
            n = order();
            case (op)
                OP_WR_MAT: mat[row*ORDER_MAX + col] = val;
                OP_WR_RHS: rhs[row] = val;
                OP_FACTOR: begin
                    sat_seen = 0;
                    bad = 0;
                    for (int j = 0; j < n && !bad; j++) begin
                        acc = mat[j*ORDER_MAX + j];
                        for (int k = 0; k < j; k++)
                            acc -= fx_mul(mat[j*ORDER_MAX + k], mat[j*ORDER_MAX + k]);
                        s = clamp32(acc);
                        if (s <= 0) begin
                            bad = 1;
                        end else begin
                            d = fx_root(s);
                            mat[j*ORDER_MAX + j] = d;
                            for (int i = j + 1; i < n; i++) begin
                                acc = mat[i*ORDER_MAX + j];
                                for (int k = 0; k < j; k++)
                                    acc -= fx_mul(mat[i*ORDER_MAX + k], mat[j*ORDER_MAX + k]);
                                mat[i*ORDER_MAX + j] = fx_div(clamp32(acc), d);
                            end
                        end
                    end
                    res.kind   = KIND_STATUS;
                    res.index  = 0;
                    res.value  = 0;
                    res.status = bad ? STAT_PIVOT : (sat_seen ? STAT_SAT : STAT_OK);
                    res.last   = 1;
                    pending_results.push_back(res);
                end
                OP_SOLVE: begin
                    sat_seen = 0;
                    bad = 0;
                    for (int i = 0; i < n; i++) begin
                        acc = rhs[i];
                        for (int j = 0; j < i; j++)
                            acc -= fx_mul(mat[i*ORDER_MAX + j], work[j]);
                        if (mat[i*ORDER_MAX + i] <= 0) bad = 1;
                        work[i] = fx_div(clamp32(acc), mat[i*ORDER_MAX + i]);
                    end
                    for (int i = n - 1; i >= 0; i--) begin
                        acc = work[i];
                        for (int j = i + 1; j < n; j++)
                            acc -= fx_mul(mat[j*ORDER_MAX + i], work[j]);
                        work[i] = fx_div(clamp32(acc), mat[i*ORDER_MAX + i]);
                    end
                    st = bad ? STAT_PIVOT : (sat_seen ? STAT_SAT : STAT_OK);
                    for (int i = 0; i < n; i++) begin
                        res.kind   = KIND_SOLUTION;
                        res.index  = i[3:0];
                        res.value  = work[i];
                        res.status = st;
                        res.last   = (i == n - 1);
                        pending_results.push_back(res);
                    end
                end
            endcase
        endfunction

        function void check_result(logic kind, logic [3:0] index, logic [31:0] value,
                                   logic [1:0] status, logic last);
            solver_result_t exp_res;
            checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result kind=%0d index=%0d value=%h",
                             kind, index, value);
                return;
            end
            exp_res = pending_results.pop_front();
            if (kind !== exp_res.kind || index !== exp_res.index ||
                value !== exp_res.value || status !== exp_res.status ||
                last !== exp_res.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: mismatch exp %0d/%0d/%h/%0d/%0d got %0d/%0d/%h/%0d/%0d",
                             exp_res.kind, exp_res.index, exp_res.value, exp_res.status,
                             exp_res.last, kind, index, value, status, last);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [4:0]  cfg_wr_data = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = 0;
    logic [1:0]  s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    cholesky_tracker tracker = new();

    bit idling_on = 1;     // cleared for the closing stretch of the run
    int stall_left = 0;
    int quiet_cycles = 0;
    int factor_count = 0;
    int solve_count = 0;
    int sizes_seen = 0;

    always #4 aclk = ~aclk;

    dense_cholesky_solver u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // Result side: accept with random back-pressure bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 0;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    // Results are sampled at the edge, before the block updates its outputs.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_result(m_tuser[0], m_tdata[3:0], m_tdata[35:4],
                                 m_tdata[37:36], m_tlast);
    end

    // Watchdog: too long with no request and no result moving means a hang.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: watchdog expired, %0d results outstanding",
                     tracker.pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // Present one request and hold it until the handshake completes.
    task automatic send_request(opcode_t op, logic [3:0] row, logic [3:0] col,
                                logic [31:0] val);
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {val, col, row};
        do @(posedge aclk); while (!s_tready);
        tracker.note_request(op, row, col, val);
        if (op == OP_FACTOR) factor_count++;
        if (op == OP_SOLVE) solve_count++;
    endtask

    // Drain outstanding results, let trailing loads settle, then set n.
    task automatic set_order(logic [4:0] val);
        s_tvalid <= 0;
        @(posedge aclk);
        while (tracker.pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_wr_en   <= 1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        tracker.note_config(val);
        sizes_seen++;
    endtask

    // Diagonally dominant lower triangle, so factoring stays well posed.
    task automatic load_system(int n);
        logic [31:0] v;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c <= r; c++) begin
                if (r == c)
                    v = (32'(n) << (FRAC + 1)) + $urandom_range(0, 32'h3ffff);
                else
                    v = $urandom_range(0, 32'h1ffff) - 32'h10000;
                send_request(OP_WR_MAT, r[3:0], c[3:0], v);
            end
            send_request(OP_WR_RHS, r[3:0], 4'($urandom), $urandom_range(0, 32'h7ffff) - 32'h40000);
        end
    endtask

    initial begin
        int n;
        int sel;
        int items;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Whole store is defined first so no later order reads stale entries.
        load_system(ORDER_MAX);
        send_request(OP_SOLVE, 4'($urandom), 4'($urandom), $urandom);  // raw matrix
        send_request(OP_FACTOR, 0, 0, 0);
        send_request(OP_SOLVE, 0, 0, 0);

        // Non-positive pivot, then a solve over a bad diagonal.
        send_request(OP_WR_MAT, 0, 0, 32'hffff_ffff);
        send_request(OP_FACTOR, 4'hf, 4'hf, 32'hffff_ffff);
        send_request(OP_SOLVE, 4'hf, 4'hf, 32'h0);

        // Field extremes, driving saturation.
        send_request(OP_WR_MAT, 0, 0, SAT_POS);
        send_request(OP_WR_MAT, 1, 0, SAT_NEG);
        send_request(OP_WR_MAT, 1, 1, 32'h0000_0001);
        send_request(OP_WR_RHS, 0, 4'hf, SAT_POS);
        send_request(OP_WR_RHS, 1, 4'h0, SAT_NEG);
        send_request(OP_FACTOR, 0, 0, 0);
        send_request(OP_SOLVE, 0, 0, 0);

        // Order extremes, including the clamped encodings.
        set_order(5'd1);
        send_request(OP_WR_MAT, 0, 0, 32'h0001_0000);
        send_request(OP_FACTOR, 0, 0, 0);
        send_request(OP_SOLVE, 0, 0, 0);
        set_order(5'd0);
        send_request(OP_SOLVE, 0, 0, 0);
        set_order(5'd31);
        send_request(OP_SOLVE, 0, 0, 0);
        set_order(5'd17);
        send_request(OP_FACTOR, 0, 0, 0);

        // Random part: mostly load/factor/solve sequences at small orders.
        items = 0;
        while (items < RANDOM_ITEMS) begin
            if (items > RANDOM_ITEMS * 4 / 5) idling_on = 0;
            sel = $urandom_range(0, 19);
            if (sel == 0)      set_order(5'($urandom_range(17, 31)));
            else if (sel == 1) set_order(5'd16);
            else if (sel == 2) set_order(5'd0);
            else               set_order(5'($urandom_range(1, 4)));
            n = tracker.order();
            if ($urandom_range(0, 3) != 0) begin
                if (n <= 4) load_system(n);
                if ($urandom_range(0, 2) == 0)
                    send_request(opcode_t'($urandom_range(0, 1)), 4'($urandom),
                                 4'($urandom), $urandom);
                send_request(OP_FACTOR, 4'($urandom), 4'($urandom), $urandom);
                send_request(OP_SOLVE, 4'($urandom), 4'($urandom), $urandom);
                items += (n <= 4) ? n * (n + 3) / 2 + 2 : 2;
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_request(opcode_t'($urandom_range(0, 3)), 4'($urandom),
                                 4'($urandom), $urandom);
                    items++;
                end
            end
        end

        s_tvalid <= 0;
        @(posedge aclk);
        while (tracker.pending_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("run: %0d factor and %0d solve requests over %0d order settings",
                 factor_count, solve_count, sizes_seen);
        $display("run: %0d results checked, %0d mismatches", tracker.checked,
                 tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
